/* sv/pbt_pkg.sv */
// ============================================================================
// pbt_pkg: shared types and constants of the packet burst tracker
// Field widths, queue item layouts, register and command codes, and
// saturating arithmetic used by the front end, the burst engine and the top.
// ============================================================================
package pbt_pkg;

    localparam int LEN_W      = 16;
    localparam int TS_W       = 48;
    localparam int CNT_W      = 32;
    localparam int GAP_W      = 32;
    localparam int MINP_W     = 8;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 32;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_GAP_US   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_PKTS = 1'b1;

    // input command codes
    localparam logic CMD_PACKET = 1'b0;
    localparam logic CMD_EXPORT = 1'b1;

    // one classified item in the command queue
    typedef struct packed {
        logic              is_export;
        logic              dir;
        logic [LEN_W-1:0]  payload_len;
        logic [TS_W-1:0]   timestamp_us;
        logic [CNT_W-1:0]  flow_packets;
    } pbt_item_t;

    // one burst record
    typedef struct packed {
        logic [CNT_W-1:0] pkts;
        logic [CNT_W-1:0] bytes;
        logic [TS_W-1:0]  start_us;
        logic [TS_W-1:0]  end_us;
    } pbt_entry_t;

    // one result in the output queue
    typedef struct packed {
        logic             burst_dir;
        logic             has_burst;
        logic [CNT_W-1:0] burst_packet_count;
        logic [CNT_W-1:0] burst_byte_count;
        logic [TS_W-1:0]  burst_start_us;
        logic [TS_W-1:0]  burst_end_us;
        logic             last;
    } pbt_result_t;

    function automatic logic [CNT_W-1:0] sat_add32(input logic [CNT_W-1:0] a,
                                                   input logic [CNT_W-1:0] b);
        logic [CNT_W:0] sum;
        begin
            sum = {1'b0, a} + {1'b0, b};
            sat_add32 = sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
        end
    endfunction

endpackage

/* sv/packet_burst_tracker.sv */
// ============================================================================
// packet_burst_tracker: per-direction packet burst statistics of one flow
// Groups packets of each direction into bursts by inter-packet gap, keeps
// the committed bursts in a memory and streams them out on flow export.
// ============================================================================
//
//  channel  | signals                                      | transfer when
//  ---------+----------------------------------------------+-----------------
//  input    | cmd, from_source, payload_len, timestamp_us,  | push && !full
//           | flow_packets                                 |
//  result   | burst_dir, has_burst, burst_packet_count,    | pop && !empty
//           | burst_byte_count, burst_start_us,            |
//           | burst_end_us, last                           |
//  config   | cfg_we, cfg_index, cfg_data                  | cfg_we
//
// Packets: one per cycle unless an export holds the engine or the command
// queue is full, each handled in the run state (gap compare, saturating
// sums, at most one write to the burst memory). Export: commit the open
// bursts (one memory write port), decide, then per reported burst a
// registered memory read and a transfer into the result queue; an empty
// export sends a single last result. Reset clears the counters and the
// started flags; the burst memory needs no clearing pass. A stalled result
// side backs up into the command queue; full rises only when that queue is full.
//
module packet_burst_tracker #(
    parameter int MAX_BURSTS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           push,
    output logic                           full,
    input  logic                           cmd,
    input  logic                           from_source,
    input  logic [pbt_pkg::LEN_W-1:0]      payload_len,
    input  logic [pbt_pkg::TS_W-1:0]       timestamp_us,
    input  logic [pbt_pkg::CNT_W-1:0]      flow_packets,

    output logic                           empty,
    input  logic                           pop,
    output logic                           burst_dir,
    output logic                           has_burst,
    output logic [pbt_pkg::CNT_W-1:0]      burst_packet_count,
    output logic [pbt_pkg::CNT_W-1:0]      burst_byte_count,
    output logic [pbt_pkg::TS_W-1:0]       burst_start_us,
    output logic [pbt_pkg::TS_W-1:0]       burst_end_us,
    output logic                           last,

    input  logic                           cfg_we,
    input  logic [pbt_pkg::CFG_ADDR_W-1:0] cfg_index,
    input  logic [pbt_pkg::CFG_DATA_W-1:0] cfg_data
);

    import pbt_pkg::*;

    localparam int CMD_DEPTH = 4;
    localparam int RES_DEPTH = 2;

    logic [GAP_W-1:0]  gap_us_reg;
    logic [MINP_W-1:0] min_pkts_reg;

    logic              cq_push;
    pbt_item_t         cq_wdata;
    logic              cq_pop;
    pbt_item_t         cq_rdata;
    logic              cq_empty;

    logic              rq_push;
    pbt_result_t       rq_wdata;
    logic              rq_full;
    pbt_result_t       rq_rdata;

    // configuration registers; the user must write them only while the block is idle (not enforced here)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_us_reg   <= GAP_W'(1000000);
            min_pkts_reg <= MINP_W'(3);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GAP_US:   gap_us_reg   <= cfg_data[GAP_W-1:0];
                REG_MIN_PKTS: min_pkts_reg <= cfg_data[MINP_W-1:0];
                default:      ;
            endcase
        end
    end

    // front end: classify and drop empty packets before they are queued
    pbt_front u_front (
        .push         (push),
        .full         (full),
        .cmd          (cmd),
        .from_source  (from_source),
        .payload_len  (payload_len),
        .timestamp_us (timestamp_us),
        .flow_packets (flow_packets),
        .q_push       (cq_push),
        .q_item       (cq_wdata)
    );

    // command queue: lets the front keep accepting while an export drains
    pbt_fifo #(
        .WIDTH ($bits(pbt_item_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cq_push),
        .wdata (cq_wdata),
        .full  (full),
        .pop   (cq_pop),
        .rdata (cq_rdata),
        .empty (cq_empty)
    );

    // back end: burst bookkeeping, burst memory and export sequencing
    pbt_back #(
        .MAX_BURSTS (MAX_BURSTS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .gap_us   (gap_us_reg),
        .min_pkts (min_pkts_reg),
        .q_empty  (cq_empty),
        .q_item   (cq_rdata),
        .q_pop    (cq_pop),
        .res_full (rq_full),
        .res_push (rq_push),
        .res      (rq_wdata)
    );

    // result queue: decouples the export stream from the consumer's pop
    pbt_fifo #(
        .WIDTH ($bits(pbt_result_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rq_push),
        .wdata (rq_wdata),
        .full  (rq_full),
        .pop   (pop),
        .rdata (rq_rdata),
        .empty (empty)
    );

    assign burst_dir          = rq_rdata.burst_dir;
    assign has_burst          = rq_rdata.has_burst;
    assign burst_packet_count = rq_rdata.burst_packet_count;
    assign burst_byte_count   = rq_rdata.burst_byte_count;
    assign burst_start_us     = rq_rdata.burst_start_us;
    assign burst_end_us       = rq_rdata.burst_end_us;
    assign last               = rq_rdata.last;

    // the engine only pushes results when the result queue has room
    a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        rq_push |-> !rq_full)
        else $error("result pushed into a full result queue");

    // the engine only takes commands that are present
    a_cmd_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        cq_pop |-> !cq_empty)
        else $error("command popped from an empty command queue");

    // an empty export result is always the final one and carries no counts
    a_empty_result_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !has_burst) |-> (last && (burst_packet_count == '0)))
        else $error("empty export result without last or with counts");

endmodule

/* sv/pbt_fifo.sv */
// ============================================================================
// pbt_fifo: small synchronous queue
// Register-based FIFO with push/full and pop/empty; the head entry is shown
// on rdata while empty is low.
// ============================================================================
module pbt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_push;
    logic             do_pop;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        begin
            ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
        end
    endfunction

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

/* sv/pbt_front.sv */
// ============================================================================
// pbt_front: input classifier
// Maps the direction flag, drops zero-payload packets and packs accepted
// items for the command queue.
// ============================================================================
module pbt_front (
    input  logic                      push,
    input  logic                      full,
    input  logic                      cmd,
    input  logic                      from_source,
    input  logic [pbt_pkg::LEN_W-1:0] payload_len,
    input  logic [pbt_pkg::TS_W-1:0]  timestamp_us,
    input  logic [pbt_pkg::CNT_W-1:0] flow_packets,
    output logic                      q_push,
    output pbt_pkg::pbt_item_t        q_item
);

    import pbt_pkg::*;

    logic is_export;
    logic empty_pkt;

    assign is_export = (cmd == CMD_EXPORT);
    // drop packets without payload here; they never touch the store
    assign empty_pkt = !is_export && (payload_len == '0);
    assign q_push    = push && !full && !empty_pkt;

    always_comb
    begin
        q_item.is_export    = is_export;
        q_item.dir          = !from_source;
        q_item.payload_len  = payload_len;
        q_item.timestamp_us = timestamp_us;
        q_item.flow_packets = flow_packets;
    end

endmodule

/* sv/pbt_back.sv */
// ============================================================================
// pbt_back: burst engine
// Holds the open burst of each direction in registers, commits finished
// bursts into the burst memory, and runs the export sequence.
// ============================================================================
module pbt_back #(
    parameter int MAX_BURSTS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [pbt_pkg::GAP_W-1:0]  gap_us,
    input  logic [pbt_pkg::MINP_W-1:0] min_pkts,
    input  logic                       q_empty,
    input  pbt_pkg::pbt_item_t         q_item,
    output logic                       q_pop,
    input  logic                       res_full,
    output logic                       res_push,
    output pbt_pkg::pbt_result_t       res
);

    import pbt_pkg::*;

    localparam int DEPTH = 2 * MAX_BURSTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_BURSTS + 1);

    localparam logic [2:0] ST_RUN   = 3'd0;
    localparam logic [2:0] ST_CMT0  = 3'd1;
    localparam logic [2:0] ST_CMT1  = 3'd2;
    localparam logic [2:0] ST_START = 3'd3;
    localparam logic [2:0] ST_ADDR  = 3'd4;
    localparam logic [2:0] ST_DATA  = 3'd5;
    localparam logic [2:0] ST_EMPTY = 3'd6;

    pbt_entry_t    mem [DEPTH];
    pbt_entry_t    rd_data_reg;
    pbt_entry_t    open_reg [2];
    logic [CW-1:0] cc_reg [2];
    logic          started_reg [2];
    logic [2:0]    state_reg;
    logic [2:0]    state_next;
    logic          flow_big_reg;
    logic          flow_big_next;
    logic          rd_dir_reg;
    logic          rd_dir_next;
    logic [CW-1:0] rd_idx_reg;
    logic [CW-1:0] rd_idx_next;

    logic          sel_dir;
    logic [CW-1:0] cc_sel;
    logic          started_sel;
    pbt_entry_t    open_sel;
    logic [TS_W:0] diff;
    logic          joins;
    logic          committable;
    logic          room;
    logic [CW-1:0] idx_inc;
    pbt_entry_t    join_entry;
    pbt_entry_t    new_entry;
    pbt_entry_t    open_wdata;
    logic          open_we;
    logic          mem_we;
    logic          rd_en;
    logic          cc_inc;
    logic          started_set;
    logic          clear;

    function automatic logic [AW-1:0] slot_addr(input logic dir, input logic [CW-1:0] n);
        begin
            slot_addr = AW'(n) + (dir ? AW'(MAX_BURSTS) : AW'(0));
        end
    endfunction

    always_comb
    begin
        case (state_reg)
            ST_RUN:  sel_dir = q_item.dir;
            ST_CMT0: sel_dir = 1'b0;
            ST_CMT1: sel_dir = 1'b1;
            default: sel_dir = rd_dir_reg;
        endcase
    end

    assign cc_sel      = cc_reg[sel_dir];
    assign started_sel = started_reg[sel_dir];
    assign open_sel    = open_reg[sel_dir];
    assign room        = (cc_sel < CW'(MAX_BURSTS));
    assign committable = (open_sel.pkts >= CNT_W'(min_pkts));
    assign idx_inc     = rd_idx_reg + 1'b1;

    // a timestamp before the burst end borrows and counts as joining
    assign diff  = {1'b0, q_item.timestamp_us} - {1'b0, open_sel.end_us};
    assign joins = diff[TS_W] || (diff[TS_W-1:0] < TS_W'(gap_us));

    always_comb
    begin
        join_entry.pkts     = (open_sel.pkts == {CNT_W{1'b1}}) ? open_sel.pkts
                                                               : open_sel.pkts + 1'b1;
        join_entry.bytes    = sat_add32(open_sel.bytes, CNT_W'(q_item.payload_len));
        join_entry.start_us = open_sel.start_us;
        join_entry.end_us   = q_item.timestamp_us;

        new_entry.pkts      = CNT_W'(1);
        new_entry.bytes     = CNT_W'(q_item.payload_len);
        new_entry.start_us  = q_item.timestamp_us;
        new_entry.end_us    = q_item.timestamp_us;
    end

    always_comb
    begin
        state_next    = state_reg;
        flow_big_next = flow_big_reg;
        rd_dir_next   = rd_dir_reg;
        rd_idx_next   = rd_idx_reg;
        q_pop         = 1'b0;
        res_push      = 1'b0;
        res           = '0;
        mem_we        = 1'b0;
        rd_en         = 1'b0;
        open_we       = 1'b0;
        open_wdata    = new_entry;
        cc_inc        = 1'b0;
        started_set   = 1'b0;
        clear         = 1'b0;

        case (state_reg)
            ST_RUN:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    if (q_item.is_export)
                    begin
                        flow_big_next = (q_item.flow_packets > CNT_W'(min_pkts));
                        state_next    = ST_CMT0;
                    end
                    else if (room)
                    begin
                        if (!started_sel)
                        begin
                            started_set = 1'b1;
                            open_we     = 1'b1;
                        end
                        else if (joins)
                        begin
                            open_we    = 1'b1;
                            open_wdata = join_entry;
                        end
                        else
                        begin
                            // close the open burst; reopen unless the direction is now full
                            mem_we  = committable;
                            cc_inc  = committable;
                            open_we = !committable || (cc_sel != CW'(MAX_BURSTS - 1));
                        end
                    end
                end
            end

            ST_CMT0, ST_CMT1:
            begin
                if (started_sel && room && committable)
                begin
                    mem_we = 1'b1;
                    cc_inc = 1'b1;
                end
                state_next = (state_reg == ST_CMT0) ? ST_CMT1 : ST_START;
            end

            ST_START:
            begin
                if (!flow_big_reg || ((cc_reg[0] == '0) && (cc_reg[1] == '0)))
                begin
                    state_next = ST_EMPTY;
                end
                else
                begin
                    rd_dir_next = (cc_reg[0] == '0);
                    rd_idx_next = '0;
                    state_next  = ST_ADDR;
                end
            end

            ST_ADDR:
            begin
                rd_en      = 1'b1;
                state_next = ST_DATA;
            end

            ST_DATA:
            begin
                if (!res_full)
                begin
                    res_push               = 1'b1;
                    res.burst_dir          = rd_dir_reg;
                    res.has_burst          = 1'b1;
                    res.burst_packet_count = rd_data_reg.pkts;
                    res.burst_byte_count   = rd_data_reg.bytes;
                    res.burst_start_us     = rd_data_reg.start_us;
                    res.burst_end_us       = rd_data_reg.end_us;
                    if (idx_inc < cc_sel)
                    begin
                        rd_idx_next = idx_inc;
                        state_next  = ST_ADDR;
                    end
                    else if (!rd_dir_reg && (cc_reg[1] != '0))
                    begin
                        rd_dir_next = 1'b1;
                        rd_idx_next = '0;
                        state_next  = ST_ADDR;
                    end
                    else
                    begin
                        res.last   = 1'b1;
                        clear      = 1'b1;
                        state_next = ST_RUN;
                    end
                end
            end

            ST_EMPTY:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    res.last   = 1'b1;
                    clear      = 1'b1;
                    state_next = ST_RUN;
                end
            end

            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_RUN;
            flow_big_reg   <= 1'b0;
            rd_dir_reg     <= 1'b0;
            rd_idx_reg     <= '0;
            cc_reg[0]      <= '0;
            cc_reg[1]      <= '0;
            started_reg[0] <= 1'b0;
            started_reg[1] <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            flow_big_reg <= flow_big_next;
            rd_dir_reg   <= rd_dir_next;
            rd_idx_reg   <= rd_idx_next;
            if (clear)
            begin
                cc_reg[0]      <= '0;
                cc_reg[1]      <= '0;
                started_reg[0] <= 1'b0;
                started_reg[1] <= 1'b0;
            end
            else
            begin
                if (cc_inc)
                begin
                    cc_reg[sel_dir] <= cc_sel + 1'b1;
                end
                if (started_set)
                begin
                    started_reg[sel_dir] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (open_we)
        begin
            open_reg[sel_dir] <= open_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[slot_addr(sel_dir, cc_sel)] <= open_sel;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[slot_addr(rd_dir_reg, rd_idx_reg)];
        end
    end

endmodule

/* tb/packet_burst_tracker_checker.sv */
`timescale 1ns / 100ps
// ============================================================================
// packet_burst_tracker_checker: result predictor and scoreboard
// Watches the input, result and register channels of the tracker, keeps its
// own copy of the burst store, and compares every result transfer with the
// oldest predicted result.
// ============================================================================
module packet_burst_tracker_checker #(
    parameter int MAX_BURSTS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           push,
    input  logic                           full,
    input  logic                           cmd,
    input  logic                           from_source,
    input  logic [pbt_pkg::LEN_W-1:0]      payload_len,
    input  logic [pbt_pkg::TS_W-1:0]       timestamp_us,
    input  logic [pbt_pkg::CNT_W-1:0]      flow_packets,

    input  logic                           empty,
    input  logic                           pop,
    input  logic                           burst_dir,
    input  logic                           has_burst,
    input  logic [pbt_pkg::CNT_W-1:0]      burst_packet_count,
    input  logic [pbt_pkg::CNT_W-1:0]      burst_byte_count,
    input  logic [pbt_pkg::TS_W-1:0]       burst_start_us,
    input  logic [pbt_pkg::TS_W-1:0]       burst_end_us,
    input  logic                           last,

    input  logic                           cfg_we,
    input  logic [pbt_pkg::CFG_ADDR_W-1:0] cfg_index,
    input  logic [pbt_pkg::CFG_DATA_W-1:0] cfg_data,

    output int                             mismatches,
    output int                             outstanding,
    output int                             results_checked,
    output int                             bursts_checked
);
    import pbt_pkg::*;

    localparam int SLOTS = 2 * MAX_BURSTS;

    logic [GAP_W-1:0]  gap_limit;
    logic [MINP_W-1:0] min_burst;

    logic [CNT_W-1:0] slot_pkts  [SLOTS];
    logic [CNT_W-1:0] slot_bytes [SLOTS];
    logic [TS_W-1:0]  slot_start [SLOTS];
    logic [TS_W-1:0]  slot_end   [SLOTS];
    int               closed     [2];
    bit               opened     [2];

    pbt_result_t burst_q [$];
    int          errs;
    int          n_results;
    int          n_bursts;

    function automatic logic [CNT_W-1:0] add_sat(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        // a + b wraps exactly when a exceeds the headroom ~b
        return (a > ~b) ? {CNT_W{1'b1}} : a + b;
    endfunction

    task automatic forget_flow();
        for (int k = 0; k < SLOTS; k++)
        begin
            slot_pkts[k]  = '0;
            slot_bytes[k] = '0;
            slot_start[k] = '0;
            slot_end[k]   = '0;
        end
        closed[0] = 0;
        closed[1] = 0;
        opened[0] = 1'b0;
        opened[1] = 1'b0;
    endtask

    task automatic start_burst(input int d, input logic [LEN_W-1:0] len,
                               input logic [TS_W-1:0] ts);
        int k;
        k = d * MAX_BURSTS + closed[d];
        slot_pkts[k]  = 1;
        slot_bytes[k] = CNT_W'(len);
        slot_start[k] = ts;
        slot_end[k]   = ts;
    endtask

    task automatic take_packet(input int d, input logic [LEN_W-1:0] len,
                               input logic [TS_W-1:0] ts);
        int k;
        if (len == 0 || closed[d] >= MAX_BURSTS)
            return;
        if (!opened[d])
        begin
            opened[d] = 1'b1;
            start_burst(d, len, ts);
            return;
        end
        k = d * MAX_BURSTS + closed[d];
        // a timestamp behind the burst end counts as a negative gap
        if (ts < slot_end[k] || (ts - slot_end[k]) < TS_W'(gap_limit))
        begin
            slot_pkts[k]  = add_sat(slot_pkts[k], 1);
            slot_bytes[k] = add_sat(slot_bytes[k], CNT_W'(len));
            slot_end[k]   = ts;
            return;
        end
        if (slot_pkts[k] >= CNT_W'(min_burst))
            closed[d]++;
        if (closed[d] < MAX_BURSTS)
            start_burst(d, len, ts);
    endtask

    task automatic export_flow(input logic [CNT_W-1:0] flow_pkts);
        pbt_result_t r;
        int          n;
        int          k;
        n = 0;
        for (int d = 0; d < 2; d++)
        begin
            if (opened[d] && closed[d] < MAX_BURSTS)
                if (slot_pkts[d * MAX_BURSTS + closed[d]] >= CNT_W'(min_burst))
                    closed[d]++;
        end
        if (flow_pkts > CNT_W'(min_burst))
        begin
            for (int d = 0; d < 2; d++)
            begin
                for (int i = 0; i < closed[d]; i++)
                begin
                    k = d * MAX_BURSTS + i;
                    r.burst_dir          = d[0];
                    r.has_burst          = 1'b1;
                    r.burst_packet_count = slot_pkts[k];
                    r.burst_byte_count   = slot_bytes[k];
                    r.burst_start_us     = slot_start[k];
                    r.burst_end_us       = slot_end[k];
                    r.last               = 1'b0;
                    burst_q.push_back(r);
                    n++;
                end
            end
        end
        if (n == 0)
        begin
            r      = '0;
            r.last = 1'b1;
            burst_q.push_back(r);
        end
        else
        begin
            burst_q[burst_q.size() - 1].last = 1'b1;
        end
        forget_flow();
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errs++;
        end
    endtask

    task automatic check_result();
        pbt_result_t want;
        pbt_result_t got;
        got = {burst_dir, has_burst, burst_packet_count, burst_byte_count,
               burst_start_us, burst_end_us, last};
        if (burst_q.size() == 0)
        begin
            $error("result transfer with no result pending");
            errs++;
            return;
        end
        want = burst_q.pop_front();
        n_results++;
        if (want.has_burst)
            n_bursts++;
        check_field("burst_dir", 64'(want.burst_dir), 64'(got.burst_dir));
        check_field("has_burst", 64'(want.has_burst), 64'(got.has_burst));
        check_field("burst_packet_count", 64'(want.burst_packet_count),
                    64'(got.burst_packet_count));
        check_field("burst_byte_count", 64'(want.burst_byte_count),
                    64'(got.burst_byte_count));
        check_field("burst_start_us", 64'(want.burst_start_us), 64'(got.burst_start_us));
        check_field("burst_end_us", 64'(want.burst_end_us), 64'(got.burst_end_us));
        check_field("last", 64'(want.last), 64'(got.last));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_limit = 32'd1000000;
            min_burst = 8'd3;
            forget_flow();
            burst_q.delete();
            errs      = 0;
            n_results = 0;
            n_bursts  = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_GAP_US)
                    gap_limit = cfg_data[GAP_W-1:0];
                else if (cfg_index == REG_MIN_PKTS)
                    min_burst = cfg_data[MINP_W-1:0];
            end
            // compare first, so a result can never match a prediction made at the same edge
            if (pop && !empty)
                check_result();
            if (push && !full)
            begin
                if (cmd == CMD_EXPORT)
                    export_flow(flow_packets);
                else
                    take_packet(from_source ? 0 : 1, payload_len, timestamp_us);
            end
        end
        mismatches      <= errs;
        outstanding     <= burst_q.size();
        results_checked <= n_results;
        bursts_checked  <= n_bursts;
    end

endmodule

/* tb/packet_burst_tracker_tb.sv */
`timescale 1ns / 100ps
// ============================================================================
// packet_burst_tracker_tb: top level of the burst tracker testbench
// Drives packet and export transfers under several register settings, with
// random gaps on the input side and random stalls on the result side; the
// checker beside the block predicts and compares every result.
// ============================================================================
module packet_burst_tracker_tb;
    import pbt_pkg::*;

    localparam int BURST_SLOTS = 16;
    // cycles to let queued packets and a trailing export drain out
    localparam int SETTLE_CYCLES = 100;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                  push         = 1'b0;
    logic                  full;
    logic                  cmd          = CMD_PACKET;
    logic                  from_source  = 1'b0;
    logic [LEN_W-1:0]      payload_len  = '0;
    logic [TS_W-1:0]       timestamp_us = '0;
    logic [CNT_W-1:0]      flow_packets = '0;

    logic                  empty;
    logic                  pop          = 1'b0;
    logic                  burst_dir;
    logic                  has_burst;
    logic [CNT_W-1:0]      burst_packet_count;
    logic [CNT_W-1:0]      burst_byte_count;
    logic [TS_W-1:0]       burst_start_us;
    logic [TS_W-1:0]       burst_end_us;
    logic                  last;

    logic                  cfg_we       = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_index    = REG_GAP_US;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    int mismatches;
    int outstanding;
    int results_checked;
    int bursts_checked;

    // stimulus bookkeeping
    logic [GAP_W-1:0]  gap_now  = 32'd1000000;
    logic [MINP_W-1:0] min_now  = 8'd3;
    logic [TS_W-1:0]   cur_ts [2];
    bit                tx_calm  = 1'b0;
    bit                rx_calm  = 1'b0;
    int                rx_wait  = 0;
    int                rx_pause = 0;
    int                packets_sent  = 0;
    int                exports_sent  = 0;
    int                settings_used = 1;

    always #4 clk = ~clk;

    packet_burst_tracker #(
        .MAX_BURSTS(BURST_SLOTS)
    ) dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .push               (push),
        .full               (full),
        .cmd                (cmd),
        .from_source        (from_source),
        .payload_len        (payload_len),
        .timestamp_us       (timestamp_us),
        .flow_packets       (flow_packets),
        .empty              (empty),
        .pop                (pop),
        .burst_dir          (burst_dir),
        .has_burst          (has_burst),
        .burst_packet_count (burst_packet_count),
        .burst_byte_count   (burst_byte_count),
        .burst_start_us     (burst_start_us),
        .burst_end_us       (burst_end_us),
        .last               (last),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    packet_burst_tracker_checker #(
        .MAX_BURSTS(BURST_SLOTS)
    ) u_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .push               (push),
        .full               (full),
        .cmd                (cmd),
        .from_source        (from_source),
        .payload_len        (payload_len),
        .timestamp_us       (timestamp_us),
        .flow_packets       (flow_packets),
        .empty              (empty),
        .pop                (pop),
        .burst_dir          (burst_dir),
        .has_burst          (has_burst),
        .burst_packet_count (burst_packet_count),
        .burst_byte_count   (burst_byte_count),
        .burst_start_us     (burst_start_us),
        .burst_end_us       (burst_end_us),
        .last               (last),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .mismatches         (mismatches),
        .outstanding        (outstanding),
        .results_checked    (results_checked),
        .bursts_checked     (bursts_checked)
    );

    // Idle length between transfers: mostly none, some short, a few long.
    // A calm side never idles, which gives back-to-back stretches.
    function automatic int pause_len(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: hold pop low for a random stall after each transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop     <= 1'b0;
            rx_wait <= 0;
        end
        else if (rx_wait != 0)
        begin
            rx_wait <= rx_wait - 1;
            pop     <= (rx_wait == 1);
        end
        else if (pop && !empty)
        begin
            rx_pause = pause_len(rx_calm);
            rx_wait <= rx_pause;
            pop     <= (rx_pause == 0);
        end
        else
        begin
            pop <= 1'b1;
        end
    end

    // Present one item and hold it until the transfer edge. Push is left
    // high on return so the next item can follow without a gap.
    task automatic send_item(input logic c, input logic fs, input logic [LEN_W-1:0] len,
                             input logic [TS_W-1:0] ts, input logic [CNT_W-1:0] fp);
        int idle;
        idle = pause_len(tx_calm);
        if (idle > 0)
        begin
            push <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        push         <= 1'b1;
        cmd          <= c;
        from_source  <= fs;
        payload_len  <= len;
        timestamp_us <= ts;
        flow_packets <= fp;
        do
            @(posedge clk);
        while (full);
        if (c == CMD_EXPORT)
            exports_sent++;
        else if (len != 0)
            packets_sent++;
    endtask

    // direction 0 is the source side
    task automatic send_packet(input int d, input logic [LEN_W-1:0] len,
                               input logic [TS_W-1:0] ts);
        send_item(CMD_PACKET, d == 0, len, ts, $urandom);
    endtask

    task automatic send_export(input logic [CNT_W-1:0] fp);
        send_item(CMD_EXPORT, 1'($urandom), LEN_W'($urandom), TS_W'({$urandom, $urandom}),
                  fp);
    endtask

    // Stop sending, wait out every pending result, then let queued packets drain.
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs(input logic [GAP_W-1:0] g, input logic [MINP_W-1:0] m);
        cfg_we    <= 1'b1;
        cfg_index <= REG_GAP_US;
        cfg_data  <= g;
        @(posedge clk);
        cfg_index <= REG_MIN_PKTS;
        cfg_data  <= CFG_DATA_W'(m);
        @(posedge clk);
        cfg_we    <= 1'b0;
        gap_now = g;
        min_now = m;
        settings_used++;
    endtask

    // One flow: a run of bursts, each opened by a gap at or past the limit and
    // filled with packets inside it, with some noise, then the export.
    task automatic run_flow(input int bursts, input int max_len, input bit one_dir);
        int              d;
        int              n;
        int              r;
        logic [TS_W-1:0] ts;
        logic [LEN_W-1:0] len;
        d = $urandom_range(0, 1);
        for (int b = 0; b < bursts; b++)
        begin
            if (!one_dir)
                d = $urandom_range(0, 1);
            n = $urandom_range(1, max_len);
            for (int j = 0; j < n; j++)
            begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    ts = TS_W'({$urandom, $urandom});
                else if (j == 0)
                    ts = cur_ts[d] + gap_now + $urandom_range(0, 2);
                else if (r < 12 || gap_now == 0)
                    ts = cur_ts[d] - $urandom_range(1, 50);
                else if (r < 20)
                    ts = cur_ts[d] + gap_now - 1;
                else
                    ts = cur_ts[d] + $urandom_range(0, gap_now - 1);
                r = $urandom_range(0, 99);
                if (r < 7)
                    len = '0;
                else if (r < 11)
                    len = '1;
                else if (r < 20)
                    len = LEN_W'($urandom);
                else
                    len = LEN_W'($urandom_range(1, 1500));
                send_packet(d, len, ts);
                if (len != 0)
                    cur_ts[d] = ts;
            end
        end
        // some exports fall on a flow too small to report
        if ($urandom_range(0, 99) < 15)
            send_export($urandom_range(0, min_now));
        else
            send_export($urandom);
        // now and then hold the sender until every result is back
        if ($urandom_range(0, 7) == 0)
            drain();
    endtask

    task automatic run_phase(input logic [GAP_W-1:0] g, input logic [MINP_W-1:0] m,
                             input int budget, input int max_len, input int deep_pct);
        int first;
        int bursts;
        drain();
        write_regs(g, m);
        tx_calm   = ($urandom_range(0, 3) == 0);
        rx_calm   = ($urandom_range(0, 3) == 0);
        cur_ts[0] = TS_W'({$urandom, $urandom});
        cur_ts[1] = TS_W'({$urandom, $urandom});
        first     = packets_sent + exports_sent;
        while (packets_sent + exports_sent - first < budget)
        begin
            // deep flows run a direction into its burst limit
            if ($urandom_range(0, 99) < deep_pct)
                bursts = $urandom_range(30, 40);
            else
                bursts = $urandom_range(0, 10);
            run_flow(bursts, max_len, $urandom_range(0, 3) == 0);
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, register values as after reset (gap 1000000, min 3).
        send_export(32'd100);                       // fresh flow: nothing to report
        send_packet(0, 16'd0, 48'd0);               // zero payload: drop
        send_packet(0, 16'hFFFF, 48'd10);
        send_packet(0, 16'd1, 48'd20);
        send_packet(0, 16'd100, 48'd5);             // behind the burst end: joins
        send_packet(0, 16'd7, 48'd1000020);         // gap equal to the limit: new burst
        send_packet(1, 16'd200, 48'hFFFF_FFFF_FFFF);
        send_packet(1, 16'd1, 48'd0);               // wrapped time: joins
        send_packet(1, 16'd2, 48'd1);
        send_packet(0, 16'd9, 48'd2000019);         // one below the limit: joins
        send_export(32'hFFFF_FFFF);                 // open burst too short in direction 0
        send_packet(1, 16'd3, 48'd100);
        send_packet(1, 16'd4, 48'd200);
        send_packet(1, 16'd5, 48'd300);
        send_export(32'd3);                         // flow count equal to min: empty
        send_export(32'd0);                         // store already cleared: empty
        send_packet(0, 16'd11, 48'd7);
        send_packet(0, 16'd12, 48'd8);
        send_packet(0, 16'd13, 48'd9);
        send_export(32'd4);

        // Random part: extremes of both registers, a zero min, then typical values.
        run_phase(32'd0, 8'd1, 45, 2, 30);
        run_phase(32'hFFFF_FFFF, 8'd255, 20, 4, 0);
        run_phase(32'd50, 8'd0, 30, 3, 20);
        run_phase(32'd1000, 8'd2, 35, 4, 15);
        run_phase($urandom_range(1, 100000), MINP_W'($urandom_range(1, 5)), 40, 7, 10);

        drain();
        $display("Sent %0d packets and %0d exports under %0d register settings.",
                 packets_sent, exports_sent, settings_used);
        $display("Checked %0d results, %0d of them carrying a burst.",
                 results_checked, bursts_checked);
        if (mismatches == 0 && outstanding == 0)
            $display("** packet_burst_tracker: PASSED **");
        else
            $display("** packet_burst_tracker: FAILED **");
        $finish;
    end

    // watchdog: far beyond the slowest correct run
    initial
    begin
        #20000000;
        $display("Timeout with %0d results still pending.", outstanding);
        $display("** packet_burst_tracker: FAILED **");
        $finish;
    end

endmodule
